### hdl/dse_pkg.sv
// Shared constants, types and helpers of the directional edge split block.
package dse_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = OUT_PTR_W + 1;

    typedef struct packed {
        logic horizontal;
        logic vertical;
        logic common;
        logic done;
    } dse_result_t;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] value,
        input logic [SIZE_W-1:0] max_value
    );
        logic [SIZE_W-1:0] result;
        if (value < SIZE_W'(3))
        begin
            result = SIZE_W'(3);
        end
        else if (value > max_value)
        begin
            result = max_value;
        end
        else
        begin
            result = value;
        end
        return result;
    endfunction

endpackage

### hdl/dse_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module dse_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/directional_edge_split_top.sv
// Top level of the directional edge split block: line buffers, edge logic and result queue.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------------
//  in      | input     | in_valid, in_stall | pixel
//  out     | output    | out_valid,out_stall| horizontal_edge, vertical_edge, common_edge,
//          |           |                    | frame_done
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// An item is taken every cycle on rows before the last while in_stall is low; each item of
// the last row yields two results, more than the one-result-per-cycle output port can drain,
// so in_stall rises there. A result is registered in the queue when its item is accepted.
// After reset the line buffers need no clearing pass: a count of columns written so far makes
// unwritten entries read as zero, so items are accepted from the first cycle.
// Results wait in a four-entry queue; in_stall rises while three or more results are queued.
module directional_edge_split_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [dse_pkg::PIX_W-1:0]           pixel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                horizontal_edge,
    output logic                                vertical_edge,
    output logic                                common_edge,
    output logic                                frame_done,
    input  logic                                cfg_we,
    input  logic [dse_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dse_pkg::SIZE_W-1:0]          cfg_data
);

    logic [dse_pkg::SIZE_W-1:0]    width_reg;
    logic [dse_pkg::SIZE_W-1:0]    height_reg;
    logic [dse_pkg::COL_W-1:0]     col_reg;
    logic [dse_pkg::COL_W-1:0]     col_next;
    logic [dse_pkg::ROW_W-1:0]     row_reg;
    logic [dse_pkg::ROW_W-1:0]     row_next;
    logic [dse_pkg::COL_W:0]       fill_reg;
    logic [dse_pkg::COL_W:0]       fill_next;
    logic                          centre_reg;
    logic                          centre_next;
    logic                          left_reg;
    logic                          first_reg;
    logic                          first_next;
    logic                          right_ok_reg;
    logic                          right_ok_next;
    logic                          up_ok_reg;
    logic                          up_ok_next;

    logic                          accept;
    logic                          pop;
    logic                          cur;
    logic                          last_col;
    logic                          last_row;
    logic                          border_col;
    logic                          top_row;
    logic                          has_upper;
    logic                          up;
    logic                          right_raw;
    logic                          right;
    logic                          ex;
    logic                          ey;
    logic [0:0]                    right_rdata;
    logic [0:0]                    up_rdata;
    logic [dse_pkg::COL_W-1:0]     right_raddr;
    logic [dse_pkg::COL_W:0]       right_addr_wide;

    dse_pkg::dse_result_t          res_upper;
    dse_pkg::dse_result_t          res_own;
    dse_pkg::dse_result_t          res_first;
    dse_pkg::dse_result_t          queue_reg [dse_pkg::OUT_DEPTH];
    logic [dse_pkg::OUT_PTR_W-1:0] head_reg;
    logic [dse_pkg::OUT_PTR_W-1:0] tail_reg;
    logic [dse_pkg::OUT_CNT_W-1:0] count_reg;
    logic [dse_pkg::OUT_CNT_W-1:0] count_next;
    logic [1:0]                    push_cnt;

    assign in_stall  = count_reg > dse_pkg::OUT_CNT_W'(2);
    assign out_valid = count_reg != '0;
    assign accept    = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    assign horizontal_edge = queue_reg[head_reg].horizontal;
    assign vertical_edge   = queue_reg[head_reg].vertical;
    assign common_edge     = queue_reg[head_reg].common;
    assign frame_done      = queue_reg[head_reg].done;

    always_comb
    begin
        cur        = pixel != '0;
        last_col   = dse_pkg::SIZE_W'(col_reg) >= (width_reg - dse_pkg::SIZE_W'(1));
        last_row   = dse_pkg::SIZE_W'(row_reg) >= (height_reg - dse_pkg::SIZE_W'(1));
        border_col = (col_reg == '0) || last_col;
        has_upper  = row_reg != '0;
        top_row    = row_reg == dse_pkg::ROW_W'(1);
        up         = up_ok_reg && up_rdata[0];
        right_raw  = right_ok_reg && right_rdata[0];
        right      = !last_col && right_raw;

        ex = 1'b0;
        ey = 1'b0;
        if (!top_row && !border_col && centre_reg)
        begin
            ex = !left_reg || !right;
            ey = !up || !cur;
        end

        res_upper.horizontal = ex || top_row;
        res_upper.vertical   = (ey && !ex) || border_col;
        res_upper.common     = ex && ey;
        res_upper.done       = 1'b0;

        res_own.horizontal = 1'b1;
        res_own.vertical   = border_col;
        res_own.common     = 1'b0;
        res_own.done       = last_col;

        res_first = has_upper ? res_upper : res_own;
        push_cnt  = 2'(has_upper) + 2'(last_row);

        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + dse_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + dse_pkg::COL_W'(1);
            row_next = row_reg;
        end

        fill_next = fill_reg;
        if ((dse_pkg::COL_W + 1)'(col_reg) == fill_reg)
        begin
            fill_next = (dse_pkg::COL_W + 1)'(col_reg) + (dse_pkg::COL_W + 1)'(1);
        end

        right_addr_wide = (dse_pkg::COL_W + 1)'(col_next) + (dse_pkg::COL_W + 1)'(1);
        right_raddr     = right_addr_wide[dse_pkg::COL_W-1:0];
        right_ok_next   = right_addr_wide < fill_next;
        up_ok_next      = (dse_pkg::COL_W + 1)'(col_next) < fill_next;
        centre_next     = last_col ? first_reg : right_raw;
        first_next      = (col_reg == '0) ? cur : first_reg;

        count_next = count_reg + (accept ? dse_pkg::OUT_CNT_W'(push_cnt) : '0)
                     - dse_pkg::OUT_CNT_W'(pop);
    end

    // The previous row buffer is read one column ahead so that each item finds its right
    // neighbor ready; the older row buffer is read at the next item's own column.
    dse_ram #(
        .WIDTH (1),
        .DEPTH (dse_pkg::MAX_WIDTH)
    ) u_prev_row (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (cur),
        .re    (accept),
        .raddr (right_raddr),
        .rdata (right_rdata)
    );

    dse_ram #(
        .WIDTH (1),
        .DEPTH (dse_pkg::MAX_WIDTH)
    ) u_older_row (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (centre_reg),
        .re    (accept),
        .raddr (col_next),
        .rdata (up_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dse_pkg::SIZE_W'(dse_pkg::MAX_WIDTH);
            height_reg <= dse_pkg::SIZE_W'(dse_pkg::MAX_HEIGHT);
        end
        else if (cfg_we)
        begin
            if (cfg_index == dse_pkg::REG_IMAGE_WIDTH)
            begin
                width_reg <= dse_pkg::clamp_size(cfg_data,
                                                 dse_pkg::SIZE_W'(dse_pkg::MAX_WIDTH));
            end
            else if (cfg_index == dse_pkg::REG_IMAGE_HEIGHT)
            begin
                height_reg <= dse_pkg::clamp_size(cfg_data,
                                                  dse_pkg::SIZE_W'(dse_pkg::MAX_HEIGHT));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            fill_reg     <= '0;
            centre_reg   <= 1'b0;
            left_reg     <= 1'b0;
            first_reg    <= 1'b0;
            right_ok_reg <= 1'b0;
            up_ok_reg    <= 1'b0;
        end
        else if (accept)
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            fill_reg     <= fill_next;
            centre_reg   <= centre_next;
            left_reg     <= centre_reg;
            first_reg    <= first_next;
            right_ok_reg <= right_ok_next;
            up_ok_reg    <= up_ok_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (pop)
            begin
                head_reg <= head_reg + dse_pkg::OUT_PTR_W'(1);
            end
            if (accept)
            begin
                tail_reg <= tail_reg + dse_pkg::OUT_PTR_W'(push_cnt);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (push_cnt != 2'd0))
        begin
            queue_reg[tail_reg] <= res_first;
        end
        if (accept && (push_cnt == 2'd2))
        begin
            queue_reg[tail_reg + dse_pkg::OUT_PTR_W'(1)] <= res_own;
        end
    end

endmodule

### hdl/directional_edge_split_checker.sv
// Port-level checks of the directional edge split block and their binding to the top level.
module directional_edge_split_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic horizontal_edge,
    input logic vertical_edge,
    input logic common_edge,
    input logic frame_done
);

    // A waiting result must stay offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("Output item withdrawn while stalled.");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable({horizontal_edge, vertical_edge, common_edge, frame_done}))
        else $error("Output item changed while stalled.");

    // The input only backs up when results are waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("Input stalled with no result queued.");

    // The last pixel of a frame lies on the bottom row and the right column.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> horizontal_edge && vertical_edge && !common_edge)
        else $error("Frame end item is not a bottom right border pixel.");

    // A common edge is an interior horizontal edge and is never in the vertical map.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && common_edge |-> horizontal_edge && !vertical_edge)
        else $error("Common edge inconsistent with horizontal and vertical maps.");

endmodule

bind directional_edge_split_top directional_edge_split_checker u_checker (.*);

### tb/sv/tb_directional_edge_split_top.sv
// Self-checking testbench for the directional edge split block, with a built-in edge predictor.
module tb_directional_edge_split_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [dse_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [dse_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [dse_pkg::PIX_W-1:0] pixel = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic horizontal_edge;
    logic vertical_edge;
    logic common_edge;
    logic frame_done;
    logic cfg_we = 1'b0;
    logic [dse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dse_pkg::SIZE_W-1:0] cfg_data = '0;

    // Predictor state, as the block holds it after reset.
    logic [dse_pkg::SIZE_W-1:0] width_reg = dse_pkg::SIZE_W'(1024);
    logic [dse_pkg::SIZE_W-1:0] height_reg = dse_pkg::SIZE_W'(1024);
    bit older_row_bits [dse_pkg::MAX_WIDTH];
    bit previous_row_bits [dse_pkg::MAX_WIDTH];
    int col_pos = 0;
    int row_pos = 0;
    bit left_above = 1'b0;
    dse_pkg::dse_result_t expected_edges [$];

    int gap_pct = 0;
    int stall_pct = 0;
    bit offering = 1'b0;
    bit start_hold = 1'b0;
    int hold_left = 0;
    int unsigned cycle_count = 0;
    int mismatches = 0;
    int results_checked = 0;
    int pixels_accepted = 0;
    int frames_seen = 0;

    directional_edge_split_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel           (pixel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .horizontal_edge (horizontal_edge),
        .vertical_edge   (vertical_edge),
        .common_edge     (common_edge),
        .frame_done      (frame_done),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int eff_size(input logic [dse_pkg::SIZE_W-1:0] value, input int limit);
        int n;
        n = int'(value);
        if (n < 3)
        begin
            n = 3;
        end
        else if (n > limit)
        begin
            n = limit;
        end
        return n;
    endfunction

    function automatic int pixels_left_in_frame();
        int w;
        int h;
        int c;
        int r;
        w = eff_size(width_reg, dse_pkg::MAX_WIDTH);
        h = eff_size(height_reg, dse_pkg::MAX_HEIGHT);
        c = (col_pos < w - 1) ? col_pos : w - 1;
        r = (row_pos < h - 1) ? row_pos : h - 1;
        return (w - c) + (h - 1 - r) * w;
    endfunction

    function automatic void predict_edges(input logic [dse_pkg::PIX_W-1:0] value);
        int w;
        int h;
        bit last_col;
        bit last_row;
        bit cur;
        bit centre;
        bit above;
        bit right_bit;
        bit border;
        bit top;
        bit ex;
        bit ey;
        dse_pkg::dse_result_t r;
        w = eff_size(width_reg, dse_pkg::MAX_WIDTH);
        h = eff_size(height_reg, dse_pkg::MAX_HEIGHT);
        last_col = col_pos >= w - 1;
        last_row = row_pos >= h - 1;
        cur = value != '0;
        centre = previous_row_bits[col_pos];
        above = older_row_bits[col_pos];
        right_bit = 1'b0;
        if (!last_col && col_pos + 1 < dse_pkg::MAX_WIDTH)
        begin
            right_bit = previous_row_bits[col_pos + 1];
        end
        border = (col_pos == 0) || last_col;
        if (row_pos >= 1)
        begin
            top = row_pos == 1;
            ex = 1'b0;
            ey = 1'b0;
            if (!top && !border && centre)
            begin
                ex = !left_above || !right_bit;
                ey = !above || !cur;
            end
            r.horizontal = ex || top;
            r.vertical = (ey && !ex) || border;
            r.common = ex && ey;
            r.done = 1'b0;
            expected_edges.push_back(r);
        end
        if (last_row)
        begin
            r.horizontal = 1'b1;
            r.vertical = border;
            r.common = 1'b0;
            r.done = last_col;
            expected_edges.push_back(r);
        end
        older_row_bits[col_pos] = centre;
        previous_row_bits[col_pos] = cur;
        left_above = centre;
        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic void compare_bit(input string field, input logic want_bit,
                                        input logic got_bit);
        if (want_bit !== got_bit)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0b, actual %0b", $time, field, want_bit, got_bit);
        end
    endfunction

    always @(posedge clk)
    begin : edge_monitor
        dse_pkg::dse_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_edges.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, actual %0b%0b%0b%0b",
                             $time, horizontal_edge, vertical_edge, common_edge, frame_done);
                end
                else
                begin
                    want = expected_edges.pop_front();
                    compare_bit("horizontal_edge", want.horizontal, horizontal_edge);
                    compare_bit("vertical_edge", want.vertical, vertical_edge);
                    compare_bit("common_edge", want.common, common_edge);
                    compare_bit("frame_done", want.done, frame_done);
                    results_checked++;
                    if (want.done)
                    begin
                        frames_seen++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pixels_accepted++;
                predict_edges(pixel);
            end
            if (cfg_we)
            begin
                if (cfg_index == dse_pkg::REG_IMAGE_WIDTH)
                begin
                    width_reg = cfg_data;
                end
                else if (cfg_index == dse_pkg::REG_IMAGE_HEIGHT)
                begin
                    height_reg = cfg_data;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (start_hold)
        begin
            start_hold = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_pixel(input logic [dse_pkg::PIX_W-1:0] value);
        while ($urandom_range(99) < gap_pct)
        begin
            if (offering)
            begin
                in_valid <= 1'b0;
                offering = 1'b0;
            end
            @(posedge clk);
        end
        if (!offering)
        begin
            in_valid <= 1'b1;
            offering = 1'b1;
        end
        pixel <= value;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_noise(input int count, input int density);
        int i;
        for (i = 0; i < count; i++)
        begin
            send_pixel(($urandom_range(99) < density) ?
                       dse_pkg::PIX_W'($urandom_range(1, 255)) : '0);
        end
    endtask

    task automatic drain_results();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (expected_edges.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [dse_pkg::CFG_IDX_W-1:0] index,
                             input logic [dse_pkg::SIZE_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input int w, input int h);
        drain_results();
        write_reg(dse_pkg::REG_IMAGE_WIDTH, dse_pkg::SIZE_W'(w));
        write_reg(dse_pkg::REG_IMAGE_HEIGHT, dse_pkg::SIZE_W'(h));
    endtask

    function automatic int random_size(input int top);
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            return $urandom_range(0, 2);
        end
        if (pick < 85)
        begin
            return $urandom_range(3, 10);
        end
        return $urandom_range(11, top);
    endfunction

    task automatic test_reset_defaults();
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h80);
        drain_results();
        write_reg(REG_SPARE_LO, dse_pkg::SIZE_W'($urandom_range(0, 2047)));
        write_reg(REG_SPARE_HI, dse_pkg::SIZE_W'($urandom_range(0, 2047)));
        set_size(0, 1);
        send_noise(pixels_left_in_frame(), 50);
    endtask

    task automatic test_directed_patterns();
        logic [dse_pkg::PIX_W-1:0] pattern [16];
        int i;
        pattern = '{8'hFF, 8'h01, 8'h00, 8'h04,
                    8'h08, 8'h10, 8'h20, 8'h00,
                    8'h40, 8'h80, 8'hFF, 8'hFF,
                    8'h02, 8'h00, 8'h00, 8'h09};
        set_size(4, 4);
        for (i = 0; i < 16; i++)
        begin
            send_pixel(pattern[i]);
        end
    endtask

    task automatic test_mid_frame_resize();
        gap_pct = 20;
        stall_pct = 20;
        set_size(20, 2047);
        send_noise(72, 50);
        set_size(8, 2047);
        send_noise(10, 50);
        set_size(30, 4);
        send_noise(pixels_left_in_frame(), 50);
        gap_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_receiver_hold();
        set_size(10, 8);
        start_hold = 1'b1;
        send_noise(80, 60);
    endtask

    task automatic run_traffic(input int item_goal, input int gap, input int stall);
        int sent;
        int total;
        int cut;
        int density;
        gap_pct = gap;
        stall_pct = stall;
        sent = 0;
        while (sent < item_goal)
        begin
            if ($urandom_range(1) == 1)
            begin
                set_size(random_size(40), random_size(16));
            end
            density = ($urandom_range(3) == 0) ? $urandom_range(90, 100) : $urandom_range(10, 90);
            total = eff_size(width_reg, dse_pkg::MAX_WIDTH) *
                    eff_size(height_reg, dse_pkg::MAX_HEIGHT);
            if ($urandom_range(4) == 0)
            begin
                cut = $urandom_range(1, total - 1);
                send_noise(cut, density);
                set_size(random_size(40), random_size(16));
                total = cut + pixels_left_in_frame();
                send_noise(total - cut, density);
            end
            else
            begin
                send_noise(total, density);
            end
            sent += total;
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(275, 0, 0);
        run_traffic(275, 85, 0);
        run_traffic(275, 0, 85);
        run_traffic(275, 38, 38);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed_patterns();
        test_mid_frame_resize();
        test_receiver_hold();
        test_random_traffic();
        drain_results();
        $display("Covered reset sizes, clamped and mid-frame size writes, spare indexes,");
        $display("a long output hold and four idle mixes: %0d pixels, %0d results, %0d frames",
                 pixels_accepted, results_checked, frames_seen);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
